@@ design/pcnms_pkg.sv @@
// ----------------------------------------------------------------------------
// pcnms_pkg
// Types and constants shared by the per-class NMS block: payload structs,
// store entry layout, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package pcnms_pkg;

    localparam int COORD_W  = 16;
    localparam int SCORE_W  = 16;
    localparam int CLASS_W  = 3;
    localparam int NUM_CLS  = 8;
    localparam int THR_W    = 17;
    localparam int CIU_W    = 4;
    localparam int AREA_W   = 2 * COORD_W;
    localparam int UNI_W    = AREA_W + 1;
    localparam int PROD_W   = THR_W + UNI_W;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam int DRAIN_CYC = 4;

    localparam logic [THR_W-1:0] THR_RESET = 17'd32768;
    localparam logic [CIU_W-1:0] CIU_RESET = 4'd3;

    // Register index taken from paddr bit 2.
    localparam logic REG_IOU_THRESHOLD  = 1'b0;
    localparam logic REG_CLASSES_IN_USE = 1'b1;

    typedef struct packed {
        logic [CLASS_W-1:0] box_class;
        logic [SCORE_W-1:0] box_score;
        logic [COORD_W-1:0] box_left;
        logic [COORD_W-1:0] box_top;
        logic [COORD_W-1:0] box_right;
        logic [COORD_W-1:0] box_bottom;
        logic               last_box;
    } in_t;

    typedef struct packed {
        logic [CLASS_W-1:0] kept_class;
        logic [SCORE_W-1:0] kept_score;
        logic [COORD_W-1:0] kept_left;
        logic [COORD_W-1:0] kept_top;
        logic [COORD_W-1:0] kept_right;
        logic [COORD_W-1:0] kept_bottom;
        logic               final_kept;
        logic               dropped_any;
    } out_t;

    typedef struct packed {
        logic [CLASS_W-1:0] cls;
        logic [SCORE_W-1:0] score;
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] bottom;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [3:0] {
        S_LOAD,
        S_SCAN,
        S_SCAN_END,
        S_PICK,
        S_FETCH,
        S_CAND,
        S_AREA,
        S_CMP,
        S_DRAIN,
        S_DECIDE,
        S_EMIT,
        S_FLUSH
    } state_t;

    typedef struct packed {
        logic               wr;
        logic               set_drop;
        logic               rd_scan;
        logic               rd_best;
        logic               rd_cmp;
        logic               pick;
        logic               cand_load;
        logic               area;
        logic               keep;
        logic               pend_load;
        logic               emit;
        logic               emit_final;
        logic               batch_clr;
        logic [CLASS_W-1:0] cls;
    } cmd_t;

    typedef struct packed {
        logic cls_ok;
        logic found;
        logic ok;
        logic pend_valid;
        logic out_free;
    } stat_t;

    function automatic logic [COORD_W-1:0] span(input logic [COORD_W-1:0] lo,
                                                input logic [COORD_W-1:0] hi);
        span = (hi > lo) ? (hi - lo) : '0;
    endfunction

endpackage

@@ design/per_class_nms.sv @@
// ----------------------------------------------------------------------------
// per_class_nms
// Per-class greedy non-maximum suppression over a batch of candidate boxes.
// ----------------------------------------------------------------------------
//  Channel | Ports                         | Moves
//  --------+-------------------------------+---------------------------------
//  input   | s_valid, s_ready, s_data      | one candidate box per transaction
//  output  | m_valid, m_ready, m_data      | one kept box per transaction
//  config  | psel, penable, pwrite, paddr, | iou_threshold at 0x0,
//          | pwdata, prdata, pready        | classes_in_use at 0x4
//
// Boxes are loaded while the sequencer sits in its load state. After the
// closing box, each of the 8 classes ends with a selection scan that finds
// nothing, and each box of a class costs its selection scan, a fetch and an
// overlap scan, and an emit step when an earlier result is handed out; the
// single read port of the box store serializes these scans. No input is
// taken until the last result of the batch sits in the output register.
// Reset needs no clearing pass. A stalled output holds the sequencer at its
// next result.
// ----------------------------------------------------------------------------
module per_class_nms #(
    parameter int MAX_BOXES = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  pcnms_pkg::in_t                s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output pcnms_pkg::out_t               m_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pcnms_pkg::PADDR_W-1:0] paddr,
    input  logic [pcnms_pkg::PDATA_W-1:0] pwdata,
    output logic [pcnms_pkg::PDATA_W-1:0] prdata,
    output logic                          pready
);

    localparam int IDX_W = $clog2(MAX_BOXES);

    pcnms_pkg::cmd_t             cmd;
    pcnms_pkg::stat_t            stat;
    logic [IDX_W-1:0]            addr, waddr;
    logic [pcnms_pkg::THR_W-1:0] iou_threshold;
    logic [pcnms_pkg::CIU_W-1:0] classes_in_use;

    pcnms_cfg u_cfg (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .iou_threshold  (iou_threshold),
        .classes_in_use (classes_in_use)
    );

    pcnms_ctrl #(
        .MAX_BOXES (MAX_BOXES)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_data.last_box),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd),
        .addr    (addr),
        .waddr   (waddr)
    );

    pcnms_dp #(
        .MAX_BOXES (MAX_BOXES)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_data         (s_data),
        .m_data         (m_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .iou_threshold  (iou_threshold),
        .classes_in_use (classes_in_use),
        .cmd            (cmd),
        .addr           (addr),
        .waddr          (waddr),
        .stat           (stat)
    );

endmodule

@@ design/pcnms_ram.sv @@
// ----------------------------------------------------------------------------
// pcnms_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pcnms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ design/pcnms_cfg.sv @@
// ----------------------------------------------------------------------------
// pcnms_cfg
// APB register file: IoU threshold and number of classes in use.
// ----------------------------------------------------------------------------
module pcnms_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pcnms_pkg::PADDR_W-1:0] paddr,
    input  logic [pcnms_pkg::PDATA_W-1:0] pwdata,
    output logic [pcnms_pkg::PDATA_W-1:0] prdata,
    output logic                          pready,
    output logic [pcnms_pkg::THR_W-1:0]   iou_threshold,
    output logic [pcnms_pkg::CIU_W-1:0]   classes_in_use
);

    logic [pcnms_pkg::THR_W-1:0] thr_reg, thr_next;
    logic [pcnms_pkg::CIU_W-1:0] ciu_reg, ciu_next;
    logic                        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb begin
        thr_next = thr_reg;
        ciu_next = ciu_reg;
        if (wr_en) begin
            case (paddr[2])
                pcnms_pkg::REG_IOU_THRESHOLD:  thr_next = pwdata[pcnms_pkg::THR_W-1:0];
                pcnms_pkg::REG_CLASSES_IN_USE: ciu_next = pwdata[pcnms_pkg::CIU_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= pcnms_pkg::THR_RESET;
            ciu_reg <= pcnms_pkg::CIU_RESET;
        end else begin
            thr_reg <= thr_next;
            ciu_reg <= ciu_next;
        end
    end

    always_comb begin
        case (paddr[2])
            pcnms_pkg::REG_IOU_THRESHOLD:
                prdata = pcnms_pkg::PDATA_W'(thr_reg);
            pcnms_pkg::REG_CLASSES_IN_USE:
                prdata = pcnms_pkg::PDATA_W'(ciu_reg);
            default: prdata = '0;
        endcase
    end

    assign iou_threshold  = thr_reg;
    assign classes_in_use = ciu_reg;

endmodule

@@ design/pcnms_ctrl.sv @@
// ----------------------------------------------------------------------------
// pcnms_ctrl
// Sequencer: loads the batch, then per class selects the best remaining box,
// runs its overlap test against kept boxes and hands results out.
// ----------------------------------------------------------------------------
module pcnms_ctrl #(
    parameter int MAX_BOXES = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_last,
    output logic                         s_ready,
    input  pcnms_pkg::stat_t             stat,
    output pcnms_pkg::cmd_t              cmd,
    output logic [$clog2(MAX_BOXES)-1:0] addr,
    output logic [$clog2(MAX_BOXES)-1:0] waddr
);

    localparam int IDX_W = $clog2(MAX_BOXES);
    localparam int CNT_W = $clog2(MAX_BOXES + 1);

    pcnms_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic [IDX_W-1:0]               addr_reg, addr_next;
    logic [pcnms_pkg::CLASS_W-1:0]  cls_reg, cls_next;
    logic [2:0]                     drain_reg, drain_next;
    logic                           fire, full, stored, scan_last, cls_last;

    assign fire      = s_valid && (state_reg == pcnms_pkg::S_LOAD);
    assign full      = (count_reg == CNT_W'(MAX_BOXES));
    assign stored    = fire && stat.cls_ok && !full;
    assign scan_last = ((CNT_W'(addr_reg) + CNT_W'(1)) == count_reg);
    assign cls_last  = (cls_reg == pcnms_pkg::CLASS_W'(pcnms_pkg::NUM_CLS - 1));
    assign s_ready   = (state_reg == pcnms_pkg::S_LOAD);
    assign addr      = addr_reg;
    assign waddr     = count_reg[IDX_W-1:0];

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pcnms_pkg::S_LOAD: begin
                if (fire && s_last && (count_reg != '0 || stored)) begin
                    state_next = pcnms_pkg::S_SCAN;
                end
            end
            pcnms_pkg::S_SCAN: begin
                if (scan_last) state_next = pcnms_pkg::S_SCAN_END;
            end
            pcnms_pkg::S_SCAN_END: state_next = pcnms_pkg::S_PICK;
            pcnms_pkg::S_PICK: begin
                if (stat.found)   state_next = pcnms_pkg::S_FETCH;
                else if (cls_last) state_next = pcnms_pkg::S_FLUSH;
                else              state_next = pcnms_pkg::S_SCAN;
            end
            pcnms_pkg::S_FETCH: state_next = pcnms_pkg::S_CAND;
            pcnms_pkg::S_CAND:  state_next = pcnms_pkg::S_AREA;
            pcnms_pkg::S_AREA:  state_next = pcnms_pkg::S_CMP;
            pcnms_pkg::S_CMP: begin
                if (scan_last) state_next = pcnms_pkg::S_DRAIN;
            end
            pcnms_pkg::S_DRAIN: begin
                if (drain_reg == '0) state_next = pcnms_pkg::S_DECIDE;
            end
            pcnms_pkg::S_DECIDE: begin
                if (stat.ok && stat.pend_valid) state_next = pcnms_pkg::S_EMIT;
                else                            state_next = pcnms_pkg::S_SCAN;
            end
            pcnms_pkg::S_EMIT: begin
                if (stat.out_free) state_next = pcnms_pkg::S_SCAN;
            end
            pcnms_pkg::S_FLUSH: begin
                if (stat.out_free) state_next = pcnms_pkg::S_LOAD;
            end
            default: state_next = pcnms_pkg::S_LOAD;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        cmd     = '0;
        cmd.cls = cls_reg;
        case (state_reg)
            pcnms_pkg::S_LOAD: begin
                cmd.wr       = stored;
                cmd.set_drop = fire && !stored;
                // A batch that closes with nothing stored yields no results.
                cmd.batch_clr = fire && s_last && count_reg == '0 && !stored;
            end
            pcnms_pkg::S_SCAN:   cmd.rd_scan   = 1'b1;
            pcnms_pkg::S_PICK:   cmd.pick      = 1'b1;
            pcnms_pkg::S_FETCH:  cmd.rd_best   = 1'b1;
            pcnms_pkg::S_CAND:   cmd.cand_load = 1'b1;
            pcnms_pkg::S_AREA:   cmd.area      = 1'b1;
            pcnms_pkg::S_CMP:    cmd.rd_cmp    = 1'b1;
            pcnms_pkg::S_DECIDE: begin
                cmd.keep      = stat.ok;
                cmd.pend_load = stat.ok && !stat.pend_valid;
            end
            pcnms_pkg::S_EMIT:  cmd.emit = stat.out_free;
            pcnms_pkg::S_FLUSH: begin
                cmd.emit_final = stat.out_free;
                cmd.batch_clr  = stat.out_free;
            end
            default: ;
        endcase
    end

    // Counters.
    always_comb begin
        count_next = count_reg;
        cls_next   = cls_reg;
        drain_next = drain_reg;
        addr_next  = '0;
        if (cmd.wr) count_next = count_reg + CNT_W'(1);
        if ((state_reg == pcnms_pkg::S_SCAN || state_reg == pcnms_pkg::S_CMP) && !scan_last) begin
            addr_next = addr_reg + IDX_W'(1);
        end
        if (state_reg == pcnms_pkg::S_PICK && !stat.found) cls_next = cls_reg + 1'b1;
        if (state_reg == pcnms_pkg::S_CMP && scan_last) drain_next = 3'(pcnms_pkg::DRAIN_CYC);
        else if (state_reg == pcnms_pkg::S_DRAIN) drain_next = drain_reg - 3'd1;
        if (cmd.batch_clr) begin
            count_next = '0;
            cls_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pcnms_pkg::S_LOAD;
            count_reg <= '0;
            addr_reg  <= '0;
            cls_reg   <= '0;
            drain_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            addr_reg  <= addr_next;
            cls_reg   <= cls_next;
            drain_reg <= drain_next;
        end
    end

endmodule

@@ design/pcnms_dp.sv @@
// ----------------------------------------------------------------------------
// pcnms_dp
// Datapath: box store, best-score selection, pipelined IoU test, pending
// result and output register.
// ----------------------------------------------------------------------------
module pcnms_dp #(
    parameter int MAX_BOXES = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  pcnms_pkg::in_t                s_data,
    output pcnms_pkg::out_t               m_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    input  logic [pcnms_pkg::THR_W-1:0]   iou_threshold,
    input  logic [pcnms_pkg::CIU_W-1:0]   classes_in_use,
    input  pcnms_pkg::cmd_t               cmd,
    input  logic [$clog2(MAX_BOXES)-1:0]  addr,
    input  logic [$clog2(MAX_BOXES)-1:0]  waddr,
    output pcnms_pkg::stat_t              stat
);

    localparam int IDX_W = $clog2(MAX_BOXES);
    localparam int CW    = pcnms_pkg::COORD_W;

    pcnms_pkg::entry_t wentry, rentry;
    logic [pcnms_pkg::ENTRY_W-1:0] rdata;
    logic [IDX_W-1:0] raddr;

    logic                 scan_v_reg, cmp_v_reg;
    logic [IDX_W-1:0]     addr_d_reg;
    logic [MAX_BOXES-1:0] done_reg, kept_reg;
    logic                 found_reg, ok_reg, drop_reg, pend_v_reg, m_valid_reg;
    logic [IDX_W-1:0]     best_idx_reg, cand_idx_reg;
    logic [pcnms_pkg::SCORE_W-1:0] best_score_reg;
    pcnms_pkg::entry_t    cand_reg, pend_reg;
    pcnms_pkg::out_t      out_reg;
    logic [pcnms_pkg::AREA_W-1:0] cand_area_reg;

    // IoU pipeline registers.
    logic          v1_reg, v2_reg, v3_reg, v4_reg;
    logic [CW-1:0] ox_reg, oy_reg, wj_reg, hj_reg;
    logic [pcnms_pkg::AREA_W-1:0] inter2_reg, areaj_reg, inter3_reg, inter4_reg;
    logic [pcnms_pkg::UNI_W-1:0]  uni_reg;
    logic [pcnms_pkg::PROD_W-1:0] prod_reg;

    logic [CW-1:0] ox, oy;
    logic          sel_hit, cmp_fail;

    assign wentry = '{cls: s_data.box_class, score: s_data.box_score,
                      left: s_data.box_left, top: s_data.box_top,
                      right: s_data.box_right, bottom: s_data.box_bottom};
    assign raddr  = cmd.rd_best ? best_idx_reg : addr;
    assign rentry = pcnms_pkg::entry_t'(rdata);

    pcnms_ram #(
        .WIDTH (pcnms_pkg::ENTRY_W),
        .DEPTH (MAX_BOXES)
    ) u_store (
        .aclk  (aclk),
        .we    (cmd.wr),
        .waddr (waddr),
        .wdata (wentry),
        .re    (cmd.rd_scan || cmd.rd_best || cmd.rd_cmp),
        .raddr (raddr),
        .rdata (rdata)
    );

    // The class field is exactly wide enough for NUM_CLS classes, so only the
    // register can reject a class.
    assign stat.cls_ok     = ({1'b0, s_data.box_class} < classes_in_use);
    assign stat.found      = found_reg;
    assign stat.ok         = ok_reg;
    assign stat.pend_valid = pend_v_reg;
    assign stat.out_free   = !m_valid_reg || m_ready;

    // Ties keep the earlier index, which matches a stable descending sort.
    assign sel_hit = scan_v_reg && rentry.cls == cmd.cls && !done_reg[addr_d_reg] &&
                     (!found_reg || rentry.score > best_score_reg);

    assign ox = pcnms_pkg::span(
        (cand_reg.left > rentry.left) ? cand_reg.left : rentry.left,
        (cand_reg.right < rentry.right) ? cand_reg.right : rentry.right);
    assign oy = pcnms_pkg::span(
        (cand_reg.top > rentry.top) ? cand_reg.top : rentry.top,
        (cand_reg.bottom < rentry.bottom) ? cand_reg.bottom : rentry.bottom);

    // A zero union implies zero overlap, so the compare passes on its own.
    assign cmp_fail = v4_reg &&
        (pcnms_pkg::PROD_W'({inter4_reg, 16'b0}) > prod_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_v_reg  <= 1'b0;
            cmp_v_reg   <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            done_reg    <= '0;
            kept_reg    <= '0;
            found_reg   <= 1'b0;
            ok_reg      <= 1'b1;
            drop_reg    <= 1'b0;
            pend_v_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            scan_v_reg <= cmd.rd_scan;
            cmp_v_reg  <= cmd.rd_cmp;
            v1_reg     <= cmp_v_reg && rentry.cls == cmd.cls && kept_reg[addr_d_reg];
            v2_reg     <= v1_reg;
            v3_reg     <= v2_reg;
            v4_reg     <= v3_reg;

            if (cmd.pick)     found_reg <= 1'b0;
            else if (sel_hit) found_reg <= 1'b1;

            if (cmd.cand_load) done_reg[best_idx_reg] <= 1'b1;
            if (cmd.keep)      kept_reg[cand_idx_reg] <= 1'b1;

            if (cmd.area)          ok_reg <= 1'b1;
            else if (cmp_fail)     ok_reg <= 1'b0;

            if (cmd.set_drop) drop_reg <= 1'b1;

            if (cmd.pend_load)       pend_v_reg <= 1'b1;
            else if (cmd.emit_final) pend_v_reg <= 1'b0;

            if (cmd.emit || cmd.emit_final) m_valid_reg <= 1'b1;
            else if (m_ready)              m_valid_reg <= 1'b0;

            if (cmd.batch_clr) begin
                done_reg <= '0;
                kept_reg <= '0;
                drop_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        addr_d_reg <= addr;
        if (sel_hit) begin
            best_idx_reg   <= addr_d_reg;
            best_score_reg <= rentry.score;
        end
        if (cmd.cand_load) begin
            cand_reg     <= rentry;
            cand_idx_reg <= best_idx_reg;
        end
        if (cmd.area) begin
            cand_area_reg <= pcnms_pkg::span(cand_reg.left, cand_reg.right) *
                             pcnms_pkg::span(cand_reg.top, cand_reg.bottom);
        end
        ox_reg     <= ox;
        oy_reg     <= oy;
        wj_reg     <= pcnms_pkg::span(rentry.left, rentry.right);
        hj_reg     <= pcnms_pkg::span(rentry.top, rentry.bottom);
        inter2_reg <= ox_reg * oy_reg;
        areaj_reg  <= wj_reg * hj_reg;
        uni_reg    <= pcnms_pkg::UNI_W'(cand_area_reg) + pcnms_pkg::UNI_W'(areaj_reg)
                      - pcnms_pkg::UNI_W'(inter2_reg);
        inter3_reg <= inter2_reg;
        prod_reg   <= iou_threshold * uni_reg;
        inter4_reg <= inter3_reg;

        if (cmd.pend_load || cmd.emit) pend_reg <= cand_reg;
        if (cmd.emit || cmd.emit_final) begin
            out_reg <= '{kept_class: pend_reg.cls, kept_score: pend_reg.score,
                         kept_left: pend_reg.left, kept_top: pend_reg.top,
                         kept_right: pend_reg.right, kept_bottom: pend_reg.bottom,
                         final_kept: cmd.emit_final, dropped_any: drop_reg};
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

@@ dv/per_class_nms_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// per_class_nms_tb
// Self-checking bench for the per-class NMS block. Batches of candidate boxes
// are sent over the input channel; a behavioral NMS predictor works out the
// kept boxes of each closed batch and every output transaction is checked
// against the oldest predicted box.
// ----------------------------------------------------------------------------
module per_class_nms_tb;

    localparam int NBOX     = 64;
    localparam int WDOG_MAX = 200000;
    localparam int HOLD_CYC = 600;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    pcnms_pkg::in_t                 s_data = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    pcnms_pkg::out_t                m_data;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [pcnms_pkg::PADDR_W-1:0]  paddr = '0;
    logic [pcnms_pkg::PDATA_W-1:0]  pwdata = '0;
    logic [pcnms_pkg::PDATA_W-1:0]  prdata;
    logic                           pready;

    always #5 aclk = ~aclk;

    per_class_nms i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Predictor state: configuration and the boxes of the open batch.
    logic [pcnms_pkg::THR_W-1:0] thr_q = pcnms_pkg::THR_RESET;
    logic [pcnms_pkg::CIU_W-1:0] ciu_q = pcnms_pkg::CIU_RESET;
    pcnms_pkg::in_t              batch[$];
    logic                        batch_drop = 1'b0;
    pcnms_pkg::out_t             kept_q[$];

    int  errors = 0;
    int  mismatches = 0;
    int  idle_cycles = 0;
    int  hold_cnt = 0;
    bit  hold_req = 1'b0;
    bit  hold_taken = 1'b0;
    bit  burst_mode = 1'b1;

    function automatic logic [15:0] axis_len(logic [15:0] lo, logic [15:0] hi);
        return (hi > lo) ? hi - lo : 16'd0;
    endfunction

    // Cross-multiplied IoU test: inter * 2^16 <= threshold * union.
    function automatic bit overlap_ok(pcnms_pkg::in_t a, pcnms_pkg::in_t b);
        logic [63:0] ox, oy, inter, uni, aa, ab;
        logic [15:0] lo, hi;
        lo = (a.box_left > b.box_left) ? a.box_left : b.box_left;
        hi = (a.box_right < b.box_right) ? a.box_right : b.box_right;
        ox = 64'(axis_len(lo, hi));
        lo = (a.box_top > b.box_top) ? a.box_top : b.box_top;
        hi = (a.box_bottom < b.box_bottom) ? a.box_bottom : b.box_bottom;
        oy = 64'(axis_len(lo, hi));
        inter = ox * oy;
        aa = 64'(axis_len(a.box_left, a.box_right)) * 64'(axis_len(a.box_top, a.box_bottom));
        ab = 64'(axis_len(b.box_left, b.box_right)) * 64'(axis_len(b.box_top, b.box_bottom));
        uni = aa + ab - inter;
        if (uni == 0) return 1'b1;
        return (inter << 16) <= 64'(thr_q) * uni;
    endfunction

    task automatic predict_box(pcnms_pkg::in_t bx);
        int              ord[$];
        int              kept[$];
        int              n, b, first;
        bit              keep;
        pcnms_pkg::out_t o;
        if (32'(bx.box_class) < 32'(ciu_q) && batch.size() < NBOX)
            batch.insert(batch.size(), bx);
        else batch_drop = 1'b1;
        if (!bx.last_box) return;
        first = kept_q.size();
        for (int c = 0; c < pcnms_pkg::NUM_CLS; c++) begin
            ord.delete();
            kept.delete();
            for (int a = 0; a < batch.size(); a++) begin
                if (batch[a].box_class != c) continue;
                // Stable insertion by descending score.
                n = ord.size();
                b = n;
                while (b > 0 && batch[ord[b-1]].box_score < batch[a].box_score) b--;
                ord.insert(b, a);
            end
            foreach (ord[i]) begin
                keep = 1'b1;
                foreach (kept[j]) if (keep) keep = overlap_ok(batch[ord[i]], batch[kept[j]]);
                if (!keep) continue;
                kept.insert(kept.size(), ord[i]);
                o.kept_class  = batch[ord[i]].box_class;
                o.kept_score  = batch[ord[i]].box_score;
                o.kept_left   = batch[ord[i]].box_left;
                o.kept_top    = batch[ord[i]].box_top;
                o.kept_right  = batch[ord[i]].box_right;
                o.kept_bottom = batch[ord[i]].box_bottom;
                o.final_kept  = 1'b0;
                o.dropped_any = batch_drop;
                kept_q.insert(kept_q.size(), o);
            end
        end
        if (kept_q.size() > first) kept_q[kept_q.size()-1].final_kept = 1'b1;
        batch.delete();
        batch_drop = 1'b0;
    endtask

    // Valid stays high after a transaction; the next call or an idle phase
    // replaces the payload or drops valid at the following falling edge.
    task automatic send_box(pcnms_pkg::in_t bx);
        s_data  <= bx;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_box(bx);
        @(negedge aclk);
    endtask

    // Random gaps between bursts on the sender side.
    task automatic send_paced(pcnms_pkg::in_t bx);
        if (burst_mode && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
        send_box(bx);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (kept_q.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [pcnms_pkg::PDATA_W-1:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (idx == pcnms_pkg::REG_IOU_THRESHOLD) thr_q = val[pcnms_pkg::THR_W-1:0];
        else ciu_q = val[pcnms_pkg::CIU_W-1:0];
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic pcnms_pkg::in_t make_box(logic [2:0] cls, logic [15:0] score,
                                                logic last);
        pcnms_pkg::in_t bx;
        logic [15:0] x, y;
        x = 16'($urandom_range(0, 60000));
        y = 16'($urandom_range(0, 60000));
        bx.box_class  = cls;
        bx.box_score  = score;
        bx.box_left   = x;
        bx.box_top    = y;
        bx.box_right  = x + 16'($urandom_range(0, 5000));
        bx.box_bottom = y + 16'($urandom_range(0, 5000));
        bx.last_box   = last;
        return bx;
    endfunction

    task automatic test_directed();
        pcnms_pkg::in_t bx;
        // Extremes of the corners, a zero-area pair, duplicate scores.
        bx = '{3'd0, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0};
        send_box(bx);
        bx = '{3'd0, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0};
        send_box(bx);
        bx = '{3'd0, 16'h0000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0};
        send_box(bx);
        bx = '{3'd0, 16'h0000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0};
        send_box(bx);
        bx = '{3'd1, 16'h1234, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b0};
        send_box(bx);
        bx = '{3'd2, 16'h5555, 16'h0100, 16'h0100, 16'h0300, 16'h0300, 1'b0};
        send_box(bx);
        bx = '{3'd2, 16'hAAAA, 16'h0200, 16'h0100, 16'h0400, 16'h0300, 1'b0};
        send_box(bx);
        // Bad class, then a closing box that is itself dropped.
        bx = '{3'd7, 16'h0001, 16'h0010, 16'h0010, 16'h0020, 16'h0020, 1'b0};
        send_box(bx);
        bx = '{3'd3, 16'h0002, 16'h0010, 16'h0010, 16'h0020, 16'h0020, 1'b1};
        send_box(bx);
        wait_drained();
        // A batch that keeps nothing.
        bx = '{3'd5, 16'h0002, 16'h0010, 16'h0010, 16'h0020, 16'h0020, 1'b1};
        send_box(bx);
        wait_drained();
    endtask

    task automatic test_config_sweep();
        logic [pcnms_pkg::THR_W-1:0] thr_set[4] = '{17'd0, 17'd65536, 17'd1, 17'd20000};
        logic [pcnms_pkg::CIU_W-1:0] ciu_set[4] = '{4'd8, 4'd1, 4'd15, 4'd0};
        for (int s = 0; s < 4; s++) begin
            write_reg(pcnms_pkg::REG_IOU_THRESHOLD, 32'(thr_set[s]));
            write_reg(pcnms_pkg::REG_CLASSES_IN_USE, 32'(ciu_set[s]));
            for (int i = 0; i < 6; i++)
                send_paced(make_box(3'($urandom_range(0, 7)),
                                    16'($urandom_range(0, 3) << 14), i == 5));
            wait_drained();
        end
        write_reg(pcnms_pkg::REG_IOU_THRESHOLD, 32'd40000);
        write_reg(pcnms_pkg::REG_CLASSES_IN_USE, 32'd8);
    endtask

    // A small batch is closed while the receiver holds off, so its results
    // back up and the next batch, which overfills the store, waits at the input.
    task automatic test_overflow();
        hold_req = 1'b1;
        for (int i = 0; i < 3; i++) send_box(make_box(3'd0, 16'($urandom), i == 2));
        for (int i = 0; i < 70; i++) send_box(make_box(3'(i % 8), 16'($urandom), i == 69));
        wait_drained();
    endtask

    task automatic test_random();
        int left, len;
        pcnms_pkg::in_t bx;
        left = 60;
        while (left > 0) begin
            len = $urandom_range(1, 12);
            burst_mode = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < len && left > 0; i++) begin
                bx = make_box(3'($urandom_range(0, 7)), 16'($urandom),
                              i == len - 1 || left == 1);
                // Clustered boxes so that suppression actually happens.
                if ($urandom_range(0, 1)) begin
                    bx.box_left   = 16'h4000 + 16'($urandom_range(0, 800));
                    bx.box_top    = 16'h4000 + 16'($urandom_range(0, 800));
                    bx.box_right  = bx.box_left + 16'($urandom_range(500, 3000));
                    bx.box_bottom = bx.box_top + 16'($urandom_range(500, 3000));
                end
                send_paced(bx);
                left--;
            end
        end
        burst_mode = 1'b1;
    endtask

    // Receiver stall pattern, with one long hold counted here on request.
    always @(negedge aclk) begin
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_cnt   = HOLD_CYC;
        end
        if (hold_cnt > 0) begin
            hold_cnt = hold_cnt - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (kept_q.size() == 0) begin
                errors++;
                if (mismatches++ < 10) $display("Unexpected result transaction %p", m_data);
            end else begin
                if (m_data !== kept_q[0]) begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("Mismatch: expected %p, actual %p", kept_q[0], m_data);
                end
                void'(kept_q.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_MAX) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_config_sweep();
        test_overflow();
        test_random();
        wait_drained();
        if (errors == 0 && kept_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
